FILE: design/bbhf_pkg.sv
// ----------------------------------------------------------------------------
// bbhf_pkg
// Types, register indexes and reset values for the battery band filter.
// ----------------------------------------------------------------------------
package bbhf_pkg;

  localparam int unsigned TIME_BITS_DEF = 32;

  localparam int unsigned PCT_W  = 7;
  localparam int unsigned RAW_W  = 8;
  localparam int unsigned MS_W   = 32;
  localparam int unsigned BAND_W = 3;
  localparam int unsigned IDX_W  = 3;

  localparam logic [PCT_W-1:0] BAND_FOUR_ENTER_RST  = 7'd75;
  localparam logic [PCT_W-1:0] BAND_THREE_ENTER_RST = 7'd50;
  localparam logic [PCT_W-1:0] BAND_TWO_ENTER_RST   = 7'd25;
  localparam logic [PCT_W-1:0] HYSTERESIS_RST       = 7'd3;
  localparam logic [MS_W-1:0]  HOLDOVER_RST         = 32'd15000;
  localparam logic [MS_W-1:0]  FULL_CONFIRM_RST     = 32'd5000;
  localparam logic [RAW_W-1:0] PCT_MAX              = 8'd100;

  localparam logic [BAND_W-1:0] BAND_NONE  = 3'd0;
  localparam logic [BAND_W-1:0] BAND_ONE   = 3'd1;
  localparam logic [BAND_W-1:0] BAND_TWO   = 3'd2;
  localparam logic [BAND_W-1:0] BAND_THREE = 3'd3;
  localparam logic [BAND_W-1:0] BAND_FOUR  = 3'd4;

  typedef enum logic [IDX_W-1:0] {
    REG_BAND_FOUR_ENTER  = 3'd0,
    REG_BAND_THREE_ENTER = 3'd1,
    REG_BAND_TWO_ENTER   = 3'd2,
    REG_HYSTERESIS       = 3'd3,
    REG_HOLDOVER_MS      = 3'd4,
    REG_FULL_CONFIRM_MS  = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic             sample_valid;
    logic [RAW_W-1:0] percent_in;
    logic             batt_found;
    logic             ext_pwr;
    logic             charging_in;
    logic             chg_term;
    logic [MS_W-1:0]  now_ms;
  } in_item_t;

  typedef struct packed {
    logic              available;
    logic [BAND_W-1:0] band;
    logic              charging_out;
    logic              full_res;
    logic              batt_low;
    logic [PCT_W-1:0]  percent_out;
  } out_item_t;

endpackage

FILE: design/battery_band_hysteresis_filter_core.sv
// ----------------------------------------------------------------------------
// battery_band_hysteresis_filter_core
// Maps power samples to a filtered battery view with band hysteresis.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_item_i) carries one power
//   sample per item; output channel (out_valid_o / out_stall_i / out_item_o)
//   carries one battery view per sample, in order.
//   Configuration writes use cfg_valid_i / cfg_ready_o with a register index
//   and 32-bit data; ready is always high. Write only while the block is idle.
//   Each item passes through the input register, then the result register.
//   Throughput: one item per cycle while the receiver does not stall; the
//   filter state is updated in the same cycle the item moves into the
//   result register.
//   When the receiver stalls, the result register holds its item and the
//   input register still takes one more item; further items see in_stall_o.
//   Reset clears both registers' valid flags, the filter state and loads
//   the default thresholds and times.
//   Timestamps are compared modulo 2^TIME_BITS.
// ----------------------------------------------------------------------------
module battery_band_hysteresis_filter_core #(
  parameter int unsigned TIME_BITS = bbhf_pkg::TIME_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  bbhf_pkg::in_item_t              in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output bbhf_pkg::out_item_t             out_item_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bbhf_pkg::IDX_W-1:0]      cfg_index_i,
  input  logic [bbhf_pkg::MS_W-1:0]       cfg_data_i
);
  import bbhf_pkg::*;

  localparam int unsigned CMP_W = (TIME_BITS > MS_W) ? TIME_BITS : MS_W;

  // configuration
  logic [PCT_W-1:0] thr_four_q, thr_three_q, thr_two_q, hyst_q;
  logic [MS_W-1:0]  holdover_q, confirm_q;

  // pipeline
  logic      in_valid_q, out_valid_q, out_free, proc;
  in_item_t  in_q;
  out_item_t out_q;

  // filter state
  logic [BAND_W-1:0]    band_q, band_d;
  logic                 full_conf_q, full_conf_d;
  logic                 full_pend_q, full_pend_d;
  logic [TIME_BITS-1:0] pend_since_q, pend_since_d;
  logic                 held_valid_q, held_valid_d;
  out_item_t            held_view_q, held_view_d;
  logic [TIME_BITS-1:0] held_time_q, held_time_d;
  out_item_t            res;

  logic [TIME_BITS-1:0] now_t, hold_elapsed, pend_elapsed;
  logic                 bad, hold_ok, charging, low, full_cond;
  logic [RAW_W-1:0]     floor_four, floor_three, floor_two;
  logic [BAND_W-1:0]    band_pick;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_four_q  <= BAND_FOUR_ENTER_RST;
      thr_three_q <= BAND_THREE_ENTER_RST;
      thr_two_q   <= BAND_TWO_ENTER_RST;
      hyst_q      <= HYSTERESIS_RST;
      holdover_q  <= HOLDOVER_RST;
      confirm_q   <= FULL_CONFIRM_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_BAND_FOUR_ENTER:  thr_four_q  <= cfg_data_i[PCT_W-1:0];
        REG_BAND_THREE_ENTER: thr_three_q <= cfg_data_i[PCT_W-1:0];
        REG_BAND_TWO_ENTER:   thr_two_q   <= cfg_data_i[PCT_W-1:0];
        REG_HYSTERESIS:       hyst_q      <= cfg_data_i[PCT_W-1:0];
        REG_HOLDOVER_MS:      holdover_q  <= cfg_data_i;
        REG_FULL_CONFIRM_MS:  confirm_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign out_free   = !out_valid_q || !out_stall_i;
  assign proc       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) in_valid_q <= in_valid_i;
      if (out_free)    out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) in_q <= in_item_i;
    if (proc) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // band selection
  assign floor_four  = (thr_four_q > hyst_q)  ? {1'b0, thr_four_q - hyst_q}  : '0;
  assign floor_three = (thr_three_q > hyst_q) ? {1'b0, thr_three_q - hyst_q} : '0;
  assign floor_two   = (thr_two_q > hyst_q)   ? {1'b0, thr_two_q - hyst_q}   : '0;

  always_comb begin
    priority if (in_q.percent_in >= {1'b0, thr_four_q}) begin
      band_pick = BAND_FOUR;
    end else if (band_q == BAND_FOUR && in_q.percent_in >= floor_four) begin
      band_pick = BAND_FOUR;
    end else if (in_q.percent_in >= {1'b0, thr_three_q}) begin
      band_pick = BAND_THREE;
    end else if ((band_q == BAND_FOUR || band_q == BAND_THREE) &&
                 in_q.percent_in >= floor_three) begin
      band_pick = BAND_THREE;
    end else if (in_q.percent_in >= {1'b0, thr_two_q}) begin
      band_pick = BAND_TWO;
    end else if ((band_q == BAND_FOUR || band_q == BAND_THREE || band_q == BAND_TWO) &&
                 in_q.percent_in >= floor_two) begin
      band_pick = BAND_TWO;
    end else begin
      band_pick = BAND_ONE;
    end
  end

  assign now_t        = TIME_BITS'(in_q.now_ms);
  assign hold_elapsed = now_t - held_time_q;
  assign pend_elapsed = now_t - pend_since_q;
  assign bad          = !in_q.sample_valid || (in_q.percent_in > PCT_MAX);
  assign hold_ok      = held_valid_q && (CMP_W'(hold_elapsed) <= CMP_W'(holdover_q));
  assign charging     = in_q.ext_pwr && (in_q.charging_in || in_q.chg_term);
  assign low          = (in_q.percent_in < {1'b0, thr_two_q}) && !charging;
  assign full_cond    = in_q.ext_pwr && in_q.chg_term;

  always_comb begin
    band_d       = band_q;
    full_conf_d  = full_conf_q;
    full_pend_d  = full_pend_q;
    pend_since_d = pend_since_q;
    held_valid_d = held_valid_q;
    held_view_d  = held_view_q;
    held_time_d  = held_time_q;
    res          = '0;
    if (bad) begin
      full_pend_d = 1'b0;
      if (hold_ok) begin
        res = held_view_q;
      end else begin
        held_valid_d = 1'b0;
        band_d       = BAND_NONE;
        full_conf_d  = 1'b0;
      end
    end else if (!in_q.batt_found) begin
      held_valid_d = 1'b0;
      band_d       = BAND_NONE;
      full_pend_d  = 1'b0;
      full_conf_d  = 1'b0;
    end else begin
      priority if (!full_cond) begin
        full_conf_d = 1'b0;
        full_pend_d = 1'b0;
      end else if (full_conf_q) begin
        full_pend_d = 1'b0;
      end else if (!full_pend_q) begin
        pend_since_d = now_t;
        full_pend_d  = 1'b1;
      end else if (CMP_W'(pend_elapsed) >= CMP_W'(confirm_q)) begin
        full_conf_d = 1'b1;
        full_pend_d = 1'b0;
      end else begin
        full_pend_d = 1'b1;
      end
      band_d           = full_conf_d ? BAND_FOUR : band_pick;
      res.available    = 1'b1;
      res.band         = band_d;
      res.charging_out = charging;
      res.full_res     = full_conf_d;
      res.batt_low     = low;
      res.percent_out  = in_q.percent_in[PCT_W-1:0];
      held_view_d      = res;
      held_time_d      = now_t;
      held_valid_d     = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_q       <= BAND_NONE;
      full_conf_q  <= 1'b0;
      full_pend_q  <= 1'b0;
      pend_since_q <= '0;
      held_valid_q <= 1'b0;
      held_view_q  <= '0;
      held_time_q  <= '0;
    end else if (proc) begin
      band_q       <= band_d;
      full_conf_q  <= full_conf_d;
      full_pend_q  <= full_pend_d;
      pend_since_q <= pend_since_d;
      held_valid_q <= held_valid_d;
      held_view_q  <= held_view_d;
      held_time_q  <= held_time_d;
    end
  end

  a_full_forces_band: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.full_res |->
      out_item_o.band == BAND_FOUR && out_item_o.available)
    else $error("full view without band four");

  a_unavail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.available |-> out_item_o == '0)
    else $error("unavailable view has nonzero fields");

  a_avail_band: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.available |->
      out_item_o.band != BAND_NONE && out_item_o.percent_out <= PCT_MAX[PCT_W-1:0])
    else $error("available view with bad band or percent");

  a_conf_band: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_conf_q |-> band_q == BAND_FOUR)
    else $error("confirmed full outside band four");

  a_pend_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_pend_q |-> !full_conf_q)
    else $error("full pending and confirmed together");

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives power samples through the battery band filter and checks every
// battery view against a cycle-free predictor of the band, full and holdover
// logic. The filter is exercised over several register settings, with
// random idle and stall bursts on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  import bbhf_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    sample_in = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   view_out;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [MS_W-1:0]  cfg_data = '0;

  battery_band_hysteresis_filter_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (sample_in),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (view_out),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // register shadow
  logic [PCT_W-1:0] enter4 = BAND_FOUR_ENTER_RST;
  logic [PCT_W-1:0] enter3 = BAND_THREE_ENTER_RST;
  logic [PCT_W-1:0] enter2 = BAND_TWO_ENTER_RST;
  logic [PCT_W-1:0] hyst_pts = HYSTERESIS_RST;
  logic [MS_W-1:0]  holdover_lim = HOLDOVER_RST;
  logic [MS_W-1:0]  confirm_lim = FULL_CONFIRM_RST;

  // filter state
  logic [BAND_W-1:0] band_now = BAND_NONE;
  logic              full_ok = 1'b0;
  logic              full_wait = 1'b0;
  logic [MS_W-1:0]   wait_since = '0;
  logic              held_ok = 1'b0;
  out_item_t         held_view = '0;
  logic [MS_W-1:0]   held_at = '0;

  in_item_t  samples_pending[$];
  out_item_t views_due[$];
  int        queued = 0;
  int        taken = 0;
  int        fail_count = 0;
  int        send_gap = 0;
  int        stall_left = 0;
  int        idle_cycles = 0;
  bit        calm = 1'b0;

  logic [MS_W-1:0] sim_ms = 32'd1000;
  int              lvl = 50;
  logic [1:0]      plug = 2'b00;

  function automatic logic [PCT_W-1:0] floor_of(logic [PCT_W-1:0] e);
    return (e > hyst_pts) ? e - hyst_pts : '0;
  endfunction

  function automatic out_item_t predict_view(in_item_t s);
    out_item_t         v;
    logic [MS_W-1:0]   age;
    logic [BAND_W-1:0] nb;
    logic              chg;
    v = '0;
    age = s.now_ms - held_at;
    if (!s.sample_valid || s.percent_in > PCT_MAX) begin
      full_wait = 1'b0;
      if (held_ok && age <= holdover_lim) return held_view;
      held_ok = 1'b0;
      band_now = BAND_NONE;
      full_ok = 1'b0;
      return v;
    end
    if (!s.batt_found) begin
      held_ok = 1'b0;
      band_now = BAND_NONE;
      full_wait = 1'b0;
      full_ok = 1'b0;
      return v;
    end
    age = s.now_ms - wait_since;
    if (!(s.ext_pwr && s.chg_term)) begin
      full_ok = 1'b0;
      full_wait = 1'b0;
    end else if (full_ok) begin
      full_wait = 1'b0;
    end else if (!full_wait) begin
      wait_since = s.now_ms;
      full_wait = 1'b1;
    end else if (age >= confirm_lim) begin
      full_ok = 1'b1;
      full_wait = 1'b0;
    end
    if (s.percent_in >= enter4 ||
        (band_now == BAND_FOUR && s.percent_in >= floor_of(enter4))) begin
      nb = BAND_FOUR;
    end else if (s.percent_in >= enter3 ||
                 ((band_now == BAND_FOUR || band_now == BAND_THREE) &&
                  s.percent_in >= floor_of(enter3))) begin
      nb = BAND_THREE;
    end else if (s.percent_in >= enter2 ||
                 (band_now >= BAND_TWO && band_now <= BAND_FOUR &&
                  s.percent_in >= floor_of(enter2))) begin
      nb = BAND_TWO;
    end else begin
      nb = BAND_ONE;
    end
    if (full_ok) nb = BAND_FOUR;
    band_now = nb;
    chg = s.ext_pwr && (s.charging_in || s.chg_term);
    v.available = 1'b1;
    v.band = nb;
    v.charging_out = chg;
    v.full_res = full_ok;
    v.batt_low = (s.percent_in < enter2) && !chg;
    v.percent_out = s.percent_in[PCT_W-1:0];
    held_view = v;
    held_at = s.now_ms;
    held_ok = 1'b1;
    return v;
  endfunction

  function automatic void queue_sample(in_item_t s);
    samples_pending.push_back(s);
    queued++;
  endfunction

  function automatic void plan_sample(bit ok, int pct, bit batt, bit vbus, bit chg,
                                      bit done, int unsigned dt);
    in_item_t s;
    sim_ms += dt;
    s.sample_valid = ok;
    s.percent_in = pct[RAW_W-1:0];
    s.batt_found = batt;
    s.ext_pwr = vbus;
    s.charging_in = chg;
    s.chg_term = done;
    s.now_ms = sim_ms;
    queue_sample(s);
  endfunction

  function automatic in_item_t roll_sample();
    in_item_t    s;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 49) == 0) sim_ms = $urandom();
    else sim_ms += $urandom_range(0, 3000);
    if ($urandom_range(0, 9) == 0) plug = 2'($urandom_range(0, 3));
    lvl = lvl + int'($urandom_range(0, 10)) - 5;
    if (lvl < 0) lvl = 0;
    if (lvl > 100) lvl = 100;
    s.sample_valid = 1'b1;
    s.percent_in = lvl[RAW_W-1:0];
    s.batt_found = 1'b1;
    s.ext_pwr = plug[1];
    s.chg_term = plug[0];
    s.charging_in = 1'($urandom_range(0, 1));
    s.now_ms = sim_ms;
    if (pick < 6) begin
      s.sample_valid = 1'b0;
      s.percent_in = RAW_W'($urandom_range(0, 255));
    end else if (pick < 11) begin
      s.percent_in = RAW_W'($urandom_range(101, 255));
    end else if (pick < 15) begin
      s.batt_found = 1'b0;
    end else if (pick < 20) begin
      lvl = $urandom_range(0, 100);
      s.percent_in = lvl[RAW_W-1:0];
    end
    return s;
  endfunction

  task automatic write_reg(input cfg_reg_e idx, input logic [MS_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    case (idx)
      REG_BAND_FOUR_ENTER:  enter4 = val[PCT_W-1:0];
      REG_BAND_THREE_ENTER: enter3 = val[PCT_W-1:0];
      REG_BAND_TWO_ENTER:   enter2 = val[PCT_W-1:0];
      REG_HYSTERESIS:       hyst_pts = val[PCT_W-1:0];
      REG_HOLDOVER_MS:      holdover_lim = val;
      REG_FULL_CONFIRM_MS:  confirm_lim = val;
      default: ;
    endcase
  endtask

  task automatic load_settings(input int p);
    case (p)
      1: begin
        write_reg(REG_BAND_FOUR_ENTER, 32'd100);
        write_reg(REG_BAND_THREE_ENTER, 32'd60);
        write_reg(REG_BAND_TWO_ENTER, 32'd0);
        write_reg(REG_HYSTERESIS, 32'd0);
        write_reg(REG_HOLDOVER_MS, 32'd0);
        write_reg(REG_FULL_CONFIRM_MS, 32'd0);
      end
      2: begin
        write_reg(REG_BAND_FOUR_ENTER, 32'd30);
        write_reg(REG_BAND_THREE_ENTER, 32'd127);
        write_reg(REG_BAND_TWO_ENTER, 32'd60);
        write_reg(REG_HYSTERESIS, 32'd127);
        write_reg(REG_HOLDOVER_MS, 32'hFFFF_FFFF);
        write_reg(REG_FULL_CONFIRM_MS, 32'hFFFF_FFFF);
      end
      3, 4: begin
        write_reg(REG_BAND_FOUR_ENTER, $urandom());
        write_reg(REG_BAND_THREE_ENTER, $urandom());
        write_reg(REG_BAND_TWO_ENTER, $urandom());
        write_reg(REG_HYSTERESIS, (p == 3) ? $urandom_range(0, 20) : $urandom());
        write_reg(REG_HOLDOVER_MS, $urandom_range(0, 20000));
        write_reg(REG_FULL_CONFIRM_MS, $urandom_range(0, 8000));
      end
      default: begin
        write_reg(REG_BAND_FOUR_ENTER, {25'd0, BAND_FOUR_ENTER_RST});
        write_reg(REG_BAND_THREE_ENTER, {25'd0, BAND_THREE_ENTER_RST});
        write_reg(REG_BAND_TWO_ENTER, {25'd0, BAND_TWO_ENTER_RST});
        write_reg(REG_HYSTERESIS, {25'd0, HYSTERESIS_RST});
        write_reg(REG_HOLDOVER_MS, HOLDOVER_RST);
        write_reg(REG_FULL_CONFIRM_MS, FULL_CONFIRM_RST);
      end
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    do @(posedge clk_i); while (taken != queued || views_due.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    int p;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // band walk with hysteresis at reset thresholds
    plan_sample(1, 80, 1, 0, 0, 0, 100);
    plan_sample(1, 73, 1, 0, 0, 0, 100);
    plan_sample(1, 71, 1, 0, 0, 0, 100);
    plan_sample(1, 47, 1, 0, 0, 0, 100);
    plan_sample(1, 46, 1, 0, 0, 0, 100);
    plan_sample(1, 22, 1, 0, 0, 0, 100);
    plan_sample(1, 21, 1, 0, 0, 0, 100);
    plan_sample(1, 24, 1, 0, 0, 0, 100);
    plan_sample(1, 100, 1, 0, 0, 0, 100);
    plan_sample(1, 0, 1, 0, 0, 0, 100);
    // invalid within holdover, then past it
    plan_sample(1, 101, 1, 0, 0, 0, 1000);
    plan_sample(0, 255, 1, 0, 0, 0, 20000);
    plan_sample(1, 60, 0, 1, 1, 0, 10);
    plan_sample(1, 60, 1, 1, 1, 0, 10);
    // full confirmation
    plan_sample(1, 90, 1, 1, 0, 1, 10);
    plan_sample(1, 90, 1, 1, 0, 1, 4999);
    plan_sample(1, 30, 1, 1, 0, 1, 1);
    plan_sample(1, 10, 1, 1, 1, 1, 10);
    plan_sample(1, 10, 1, 0, 0, 1, 10);
    // confirmation across the timestamp wrap
    sim_ms = 32'hFFFF_FF00;
    plan_sample(1, 55, 1, 1, 1, 1, 0);
    plan_sample(1, 55, 1, 1, 1, 1, 5200);
    plan_sample(0, 12, 1, 1, 1, 1, 100);
    plan_sample(1, 100, 1, 0, 1, 0, 5);
    plan_sample(0, 128, 0, 0, 0, 0, 5);
    repeat (150) queue_sample(roll_sample());
    drain();

    for (p = 1; p <= 5; p++) begin
      load_settings(p);
      calm = (p == 5);
      repeat (175) queue_sample(roll_sample());
      drain();
    end

    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // sample driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        views_due.push_back(predict_view(sample_in));
        taken++;
        if (!calm && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 18);
      end
      if (in_valid && in_stall) begin
        in_valid <= 1'b1;
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (samples_pending.size() > 0) begin
        sample_in <= samples_pending.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // view monitor
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        if (views_due.size() == 0) begin
          $error("unexpected battery view %p", view_out);
          fail_count++;
        end else begin
          want = views_due.pop_front();
          if (view_out.available !== want.available) begin
            $error("available: expected %0d, got %0d", want.available, view_out.available);
            fail_count++;
          end
          if (view_out.band !== want.band) begin
            $error("band: expected %0d, got %0d", want.band, view_out.band);
            fail_count++;
          end
          if (view_out.charging_out !== want.charging_out) begin
            $error("charging_out: expected %0d, got %0d", want.charging_out,
                   view_out.charging_out);
            fail_count++;
          end
          if (view_out.full_res !== want.full_res) begin
            $error("full_res: expected %0d, got %0d", want.full_res, view_out.full_res);
            fail_count++;
          end
          if (view_out.batt_low !== want.batt_low) begin
            $error("batt_low: expected %0d, got %0d", want.batt_low,
                   view_out.batt_low);
            fail_count++;
          end
          if (view_out.percent_out !== want.percent_out) begin
            $error("percent_out: expected %0d, got %0d", want.percent_out,
                   view_out.percent_out);
            fail_count++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        stall_left = $urandom_range(0, 17);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

endmodule
